// ----- rtl/gpf_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the byte-wise crc-16 update for the gamepad framer
// no dependencies

package gpf_pkg;

  // frame geometry
  localparam int unsigned FrameLen = 13;
  localparam int unsigned StoreLen = 11;
  localparam int unsigned StoreW   = StoreLen * 8;
  localparam int unsigned PosW     = 4;

  // byte positions within a frame
  localparam logic [PosW-1:0] PosFirstCrc = PosW'(1);
  localparam logic [PosW-1:0] PosLastCrc  = PosW'(StoreLen - 1);
  localparam logic [PosW-1:0] PosCrcHi    = PosW'(StoreLen);
  localparam logic [PosW-1:0] PosCrcLo    = PosW'(FrameLen - 1);

  // crc-16 constants, msb first, no final xor
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // configuration register map
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;
  localparam logic [CfgIdxW-1:0] CfgDeadZone = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgHeader   = CfgIdxW'(1);

  // reset values of the configuration registers
  localparam logic [14:0] DeadZoneRst = 15'd7849;
  localparam logic [7:0]  HeaderRst   = 8'h0A;

  // crc unit control
  typedef struct packed {
    logic init;
    logic upd;
  } crc_ctrl_t;

  // byte shift register control
  typedef struct packed {
    logic load;
    logic shift;
  } shreg_ctrl_t;

  // one byte through the crc, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/gpf_crc.sv -----
`timescale 1ns / 1ps
// crc-16 check register, updated one byte per cycle while ctrl_i.upd is set
// depends on gpf_pkg

module gpf_crc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gpf_pkg::crc_ctrl_t ctrl_i,
  input  logic [7:0]         byte_i,
  output logic [15:0]        crc_o
);

  logic [15:0] crc_d, crc_q;

  // restart on a new frame, fold in one byte when asked
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = gpf_pkg::CrcInit;
    end else if (ctrl_i.upd) begin
      crc_d = gpf_pkg::crc_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= gpf_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ----- rtl/gpf_shreg.sv -----
`timescale 1ns / 1ps
// frame byte shift register, parallel load and one byte out per shift
// depends on gpf_pkg

module gpf_shreg (
  input  logic                        clk_i,
  input  gpf_pkg::shreg_ctrl_t        ctrl_i,
  input  logic [gpf_pkg::StoreW-1:0]  load_i,
  output logic [7:0]                  head_o
);

  logic [gpf_pkg::StoreW-1:0] sr_d, sr_q;

  // load wins over shift, byte 0 sits at the top
  always_comb begin
    sr_d = sr_q;
    if (ctrl_i.load) begin
      sr_d = load_i;
    end else if (ctrl_i.shift) begin
      sr_d = {sr_q[gpf_pkg::StoreW-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign head_o = sr_q[gpf_pkg::StoreW-1 -: 8];

endmodule

// ----- rtl/gamepad_packet_framer_crc16_core.sv -----
`timescale 1ns / 1ps
// gamepad framer top: packs a snapshot, streams 13 bytes with crc-16 trailer
// depends on gpf_pkg, gpf_shreg, gpf_crc
// the header byte leaves through the shift register, then the output register
// one byte per cycle through the shift register while the receiver is ready
// a new snapshot is taken in the cycle the last crc byte is loaded for output
// reset: asynchronous active low, clears control, crc to 0xFFFF, config to defaults

module gamepad_packet_framer_crc16_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [gpf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gpf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // snapshot channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    main_buttons_i,
  input  logic [5:0]                    extra_buttons_i,
  input  logic [7:0]                    left_trigger_i,
  input  logic [7:0]                    right_trigger_i,
  input  logic signed [15:0]            left_stick_x_i,
  input  logic signed [15:0]            left_stick_y_i,
  input  logic signed [15:0]            right_stick_x_i,
  input  logic signed [15:0]            right_stick_y_i,
  // frame byte channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    frame_byte_o,
  output logic                          last_byte_o
);

  logic [14:0] dead_zone_q;
  logic [7:0]  header_q;

  logic                      busy_d, busy_q;
  logic [gpf_pkg::PosW-1:0]  pos_d, pos_q;
  logic                      oval_d, oval_q;
  logic [7:0]                obyte_d, obyte_q;
  logic                      olast_d, olast_q;

  logic advance, last_adv, in_acc;
  logic [7:0]  head, cur_byte, byte10;
  logic [15:0] crc;
  logic [15:0] sz [4];
  logic [gpf_pkg::StoreW-1:0] load_val;
  gpf_pkg::crc_ctrl_t   crc_ctrl;
  gpf_pkg::shreg_ctrl_t sr_ctrl;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= gpf_pkg::DeadZoneRst;
      header_q    <= gpf_pkg::HeaderRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gpf_pkg::CfgDeadZone: dead_zone_q <= cfg_wdata_i[14:0];
        gpf_pkg::CfgHeader:   header_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // dead zone: zero a stick value whose magnitude is below the threshold
  function automatic logic [15:0] dz_apply(input logic [15:0] v, input logic [14:0] dz);
    logic [16:0] mag;
    mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    return (mag < {2'b00, dz}) ? 16'h0000 : v;
  endfunction

  // pack bytes 0..10 of the frame
  always_comb begin
    sz[0] = dz_apply(left_stick_x_i, dead_zone_q);
    sz[1] = dz_apply(left_stick_y_i, dead_zone_q);
    sz[2] = dz_apply(right_stick_x_i, dead_zone_q);
    sz[3] = dz_apply(right_stick_y_i, dead_zone_q);
    byte10 = {extra_buttons_i[5:2], left_trigger_i != 8'h00,
              right_trigger_i != 8'h00, extra_buttons_i[1:0]};
    load_val = {header_q, main_buttons_i, sz[0], sz[1], sz[2], sz[3], byte10};
  end

  // handshake and sequencing
  assign advance    = busy_q && (!oval_q || out_ready_i);
  assign last_adv   = advance && (pos_q == gpf_pkg::PosCrcLo);
  assign in_ready_o = !busy_q || last_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign sr_ctrl.load   = in_acc;
  assign sr_ctrl.shift  = advance;
  assign crc_ctrl.init  = in_acc;
  assign crc_ctrl.upd   = advance && (pos_q >= gpf_pkg::PosFirstCrc) &&
                          (pos_q <= gpf_pkg::PosLastCrc);

  gpf_shreg u_shreg (
    .clk_i  (clk_i),
    .ctrl_i (sr_ctrl),
    .load_i (load_val),
    .head_o (head)
  );

  gpf_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (head),
    .crc_o  (crc)
  );

  // byte source: stored bytes, then the crc high and low bytes
  always_comb begin
    case (pos_q)
      gpf_pkg::PosCrcHi: cur_byte = crc[15:8];
      gpf_pkg::PosCrcLo: cur_byte = crc[7:0];
      default:           cur_byte = head;
    endcase
  end

  // next-state for position, busy flag and output register
  always_comb begin
    busy_d  = busy_q;
    pos_d   = pos_q;
    oval_d  = oval_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (advance) begin
      pos_d   = pos_q + gpf_pkg::PosW'(1);
      oval_d  = 1'b1;
      obyte_d = cur_byte;
      olast_d = (pos_q == gpf_pkg::PosCrcLo);
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
    if (last_adv) begin
      busy_d = 1'b0;
      pos_d  = '0;
    end
    if (in_acc) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = oval_q;
  assign frame_byte_o = obyte_q;
  assign last_byte_o  = olast_q;

endmodule

// ----- rtl/gpf_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for the gamepad framer, with its bind to the top level
// depends on gamepad_packet_framer_crc16_core

module gpf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [7:0] frame_byte_o,
  input logic last_byte_o
);

  logic [3:0] dcnt_q;
  logic [1:0] pend_q;
  logic in_acc, out_acc, done;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign done    = out_acc && last_byte_o;

  // delivered bytes of the current frame and frames still owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      pend_q <= '0;
    end else begin
      if (done) begin
        dcnt_q <= '0;
      end else if (out_acc) begin
        dcnt_q <= dcnt_q + 4'd1;
      end
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, done};
    end
  end

  // a stalled transaction holds its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o) &&
    $stable(last_byte_o))
    else $error("stalled frame byte changed");

  // last mark sits on the thirteenth byte only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_byte_o == (dcnt_q == 4'd12)))
    else $error("last byte mark misplaced");

  // a new snapshot is taken only between frames or near the end of the previous frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (dcnt_q == 4'd0) || (dcnt_q == 4'd11) || (dcnt_q == 4'd12))
    else $error("snapshot taken mid frame");

  // bytes appear only for a snapshot that was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (pend_q != 2'd0))
    else $error("frame byte without snapshot");

endmodule

bind gamepad_packet_framer_crc16_core gpf_checker u_gpf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

// ----- test/gamepad_packet_framer_crc16_core_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the gamepad framer: frame prediction, crc-16 and dead zone
// depends on gpf_pkg and gamepad_packet_framer_crc16_core

module gamepad_packet_framer_crc16_core_test;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned MaxReports  = 10;

  // register indexes with no register behind them
  localparam logic [gpf_pkg::CfgIdxW-1:0] CfgNoReg2 = gpf_pkg::CfgIdxW'(2);
  localparam logic [gpf_pkg::CfgIdxW-1:0] CfgNoReg3 = gpf_pkg::CfgIdxW'(3);

  typedef struct packed {
    logic [7:0]         main_buttons;
    logic [5:0]         extra_buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_stick_x;
    logic signed [15:0] left_stick_y;
    logic signed [15:0] right_stick_x;
    logic signed [15:0] right_stick_y;
  } snapshot_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // expected frame bytes, built from the snapshots the block accepted
  class frame_scoreboard;
    logic [14:0]  dead_zone;
    logic [7:0]   header;
    frame_byte_t  frame_q[$];
    int unsigned  mismatches;

    function new();
      dead_zone  = gpf_pkg::DeadZoneRst;
      header     = gpf_pkg::HeaderRst;
      mismatches = 0;
    endfunction

    function void write_reg(logic [gpf_pkg::CfgIdxW-1:0] idx,
                            logic [gpf_pkg::CfgDataW-1:0] wdata);
      case (idx)
        gpf_pkg::CfgDeadZone: dead_zone = wdata[14:0];
        gpf_pkg::CfgHeader:   header = wdata[7:0];
        default: ;
      endcase
    endfunction

    // magnitude at full precision, so -32768 is never zeroed
    function logic [15:0] dead_zone_filter(logic signed [15:0] v);
      int mag;
      mag = (v < 0) ? -int'(v) : int'(v);
      return (mag < int'(dead_zone)) ? 16'h0000 : v;
    endfunction

    // crc-16 0x1021, one data bit per step, msb first
    function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] d);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb  = crc[15] ^ d[k];
        crc = {crc[14:0], 1'b0};
        if (fb) begin
          crc = crc ^ 16'h1021;
        end
      end
      return crc;
    endfunction

    function void note_snapshot(snapshot_t s);
      logic [7:0]  fr [13];
      logic [15:0] st [4];
      logic [15:0] crc;
      st[0] = dead_zone_filter(s.left_stick_x);
      st[1] = dead_zone_filter(s.left_stick_y);
      st[2] = dead_zone_filter(s.right_stick_x);
      st[3] = dead_zone_filter(s.right_stick_y);
      fr[0] = header;
      fr[1] = s.main_buttons;
      for (int i = 0; i < 4; i++) begin
        fr[2 + 2 * i] = st[i][15:8];
        fr[3 + 2 * i] = st[i][7:0];
      end
      fr[10] = {s.extra_buttons[5:2], s.left_trigger != 8'd0, s.right_trigger != 8'd0,
                s.extra_buttons[1:0]};
      // header byte stays outside the crc
      crc = 16'hFFFF;
      for (int i = 1; i <= 10; i++) begin
        crc = crc_step(crc, fr[i]);
      end
      fr[11] = crc[15:8];
      fr[12] = crc[7:0];
      for (int i = 0; i < 13; i++) begin
        frame_q.push_back('{data: fr[i], last: (i == 12)});
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_byte_t want;
      if (frame_q.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("unexpected frame byte %02h last %0b", data, last);
        end
        mismatches++;
        return;
      end
      want = frame_q.pop_front();
      if (want.data !== data || want.last !== last) begin
        if (mismatches < MaxReports) begin
          $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                   want.data, want.last, data, last);
        end
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return frame_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [gpf_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [gpf_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0]  main_buttons_i;
  logic [5:0]  extra_buttons_i;
  logic [7:0]  left_trigger_i;
  logic [7:0]  right_trigger_i;
  logic signed [15:0] left_stick_x_i;
  logic signed [15:0] left_stick_y_i;
  logic signed [15:0] right_stick_x_i;
  logic signed [15:0] right_stick_y_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [7:0] frame_byte_o;
  logic last_byte_o;

  frame_scoreboard sb = new();
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        rx_held = 1'b0;
  int unsigned cycle_count;

  gamepad_packet_framer_crc16_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .main_buttons_i  (main_buttons_i),
    .extra_buttons_i (extra_buttons_i),
    .left_trigger_i  (left_trigger_i),
    .right_trigger_i (right_trigger_i),
    .left_stick_x_i  (left_stick_x_i),
    .left_stick_y_i  (left_stick_y_i),
    .right_stick_x_i (right_stick_x_i),
    .right_stick_y_i (right_stick_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_byte_o    (frame_byte_o),
    .last_byte_o     (last_byte_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // frame byte receiver: ready set at the falling edge, transaction checked at the rising edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = !rx_held && ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_byte(frame_byte_o, last_byte_o);
      end
    end
  end

  function automatic snapshot_t make_snap(logic [7:0] mb, logic [5:0] eb, logic [7:0] lt,
                                          logic [7:0] rt, int lx, int ly, int rx, int ry);
    snapshot_t s;
    s.main_buttons  = mb;
    s.extra_buttons = eb;
    s.left_trigger  = lt;
    s.right_trigger = rt;
    s.left_stick_x  = 16'(lx);
    s.left_stick_y  = 16'(ly);
    s.right_stick_x = 16'(rx);
    s.right_stick_y = 16'(ry);
    return s;
  endfunction

  // stick values clustered around the dead zone edges and the extremes
  function automatic int rand_stick();
    int dz;
    dz = int'(sb.dead_zone);
    case ($urandom_range(5))
      0: return int'($urandom_range(65535)) - 32768;
      1: return $urandom_range(1) ? dz : -dz;
      2: return $urandom_range(1) ? dz - 1 : 1 - dz;
      3: begin
        case ($urandom_range(3))
          0: return 32767;
          1: return -32768;
          2: return 0;
          default: return -1;
        endcase
      end
      4: return $urandom_range(1) ? int'($urandom_range(dz)) : -int'($urandom_range(dz));
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic snapshot_t random_snapshot();
    logic [7:0] lt;
    logic [7:0] rt;
    lt = $urandom_range(2) == 0 ? 8'd0 : 8'($urandom);
    rt = $urandom_range(2) == 0 ? 8'd0 : 8'($urandom);
    return make_snap(8'($urandom), 6'($urandom), lt, rt,
                     rand_stick(), rand_stick(), rand_stick(), rand_stick());
  endfunction

  // offer one snapshot; called and returns at a falling edge, valid left high
  task automatic send_snapshot(snapshot_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    main_buttons_i  = s.main_buttons;
    extra_buttons_i = s.extra_buttons;
    left_trigger_i  = s.left_trigger;
    right_trigger_i = s.right_trigger;
    left_stick_x_i  = s.left_stick_x;
    left_stick_y_i  = s.left_stick_y;
    right_stick_x_i = s.right_stick_x;
    right_stick_y_i = s.right_stick_y;
    in_valid_i      = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sb.note_snapshot(s);
    @(negedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_snapshot(random_snapshot());
    end
    in_valid_i = 1'b0;
  endtask

  task automatic write_cfg(logic [gpf_pkg::CfgIdxW-1:0] idx,
                           logic [gpf_pkg::CfgDataW-1:0] wdata);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = wdata;
    sb.write_reg(idx, wdata);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every expected byte came out, then let the block settle
  task automatic wait_drained();
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // receiver held off for a long stretch so the block backs up into its input
  task automatic hold_receiver();
    @(posedge clk_i);
    rx_held = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_held = 1'b0;
  endtask

  task automatic run_phase(int unsigned count, int unsigned tx_pct, int unsigned rx_pct,
                           bit with_hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    fork
      if (with_hold) hold_receiver();
      send_random(count);
    join
    wait_drained();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = gpf_pkg::CfgDeadZone;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    main_buttons_i  = '0;
    extra_buttons_i = '0;
    left_trigger_i  = '0;
    right_trigger_i = '0;
    left_stick_x_i  = '0;
    left_stick_y_i  = '0;
    right_stick_x_i = '0;
    right_stick_y_i = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 30;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset configuration: field extremes and dead zone edges
    send_snapshot(make_snap(8'h00, 6'h00, 8'h00, 8'h00, 0, 0, 0, 0));
    send_snapshot(make_snap(8'hFF, 6'h3F, 8'hFF, 8'hFF, 32767, 32767, 32767, 32767));
    send_snapshot(make_snap(8'h00, 6'h00, 8'h01, 8'h00, -32768, -32768, -32768, -32768));
    send_snapshot(make_snap(8'h81, 6'h01, 8'h00, 8'h01, 7849, -7849, 7848, -7848));
    send_snapshot(make_snap(8'hA5, 6'h2A, 8'h80, 8'h00, -1, 1, 32767, -32767));
    send_snapshot(make_snap(8'h5A, 6'h15, 8'h80, 8'h80, 21845, -21846, 4660, -4660));
    in_valid_i = 1'b0;
    wait_drained();

    // zero dead zone, header written with bits above its width, unmapped indexes
    write_cfg(gpf_pkg::CfgDeadZone, 15'd0);
    write_cfg(gpf_pkg::CfgHeader, 15'h7F5A);
    write_cfg(CfgNoReg2, 15'h7FFF);
    write_cfg(CfgNoReg3, 15'h1234);
    send_snapshot(make_snap(8'h01, 6'h3F, 8'h00, 8'h00, 0, 1, -1, -32768));
    send_snapshot(make_snap(8'h80, 6'h00, 8'hFF, 8'h00, 2, -2, 32767, -32767));
    in_valid_i = 1'b0;
    wait_drained();

    // largest dead zone, header of zero
    write_cfg(gpf_pkg::CfgDeadZone, 15'd32767);
    write_cfg(gpf_pkg::CfgHeader, 15'h0000);
    send_snapshot(make_snap(8'h3C, 6'h0C, 8'h00, 8'h7F, 32767, -32767, 32766, -32768));
    send_snapshot(make_snap(8'hC3, 6'h33, 8'h10, 8'h00, -32766, 0, 1, -32768));
    in_valid_i = 1'b0;
    wait_drained();

    // random phases: receiver sparse first, then sender sparse, then full rate
    write_cfg(gpf_pkg::CfgDeadZone, 15'($urandom_range(32767)));
    write_cfg(gpf_pkg::CfgHeader, 15'($urandom));
    run_phase(44, 17, 62, 1'b1);

    write_cfg(gpf_pkg::CfgDeadZone, 15'($urandom_range(12000)));
    write_cfg(gpf_pkg::CfgHeader, 15'($urandom));
    run_phase(44, 62, 17, 1'b0);

    write_cfg(gpf_pkg::CfgDeadZone, 15'($urandom_range(2000)));
    write_cfg(gpf_pkg::CfgHeader, 15'($urandom));
    run_phase(44, 0, 0, 1'b1);

    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
